@@ rtl/lsr_pkg.sv @@
package lsr_pkg;

    // Default largest grid side; sizes the line memory.
    localparam int MAX_GRID_DEF = 32;

    localparam int U_W     = 24;  // signed Q8.16 value
    localparam int DU_W    = 24;  // signed Q8.16 derivative
    localparam int COEFF_W = 24;  // unsigned Q16.8
    localparam int GRID_W  = 6;
    localparam int RES_W   = 32;  // signed Q16.16

    // Four neighbors minus four times the center, exact.
    localparam int LAP_W  = U_W + 3;
    // lap times coeff (coeff zero-extended to signed).
    localparam int PROD_W = LAP_W + COEFF_W + 1;
    // du minus the rounded product, before saturation.
    localparam int DIFF_W = PROD_W - 7;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [GRID_W-1:0]  GRID_MIN  = 6'd3;
    localparam logic [GRID_W-1:0]  GRID_RST  = 6'd10;
    localparam logic [COEFF_W-1:0] COEFF_RST = 24'd20736;

    // One line memory entry per column: newest row and the row before it.
    typedef struct packed {
        logic signed [U_W-1:0]  u1;
        logic signed [DU_W-1:0] d1;
        logic signed [U_W-1:0]  u2;
    } line_t;

    // Result request from the sequencer to the arithmetic pipeline.
    typedef struct packed {
        logic                    interior;
        logic                    last;
        logic signed [U_W-1:0]   value;
        logic signed [DU_W-1:0]  deriv;
        logic signed [LAP_W-1:0] lap;
    } req_t;

endpackage

@@ rtl/lsr_line_mem.sv @@
module lsr_line_mem #(
    parameter int DEPTH = lsr_pkg::MAX_GRID_DEF
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  lsr_pkg::line_t             wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output lsr_pkg::line_t             rdata
);

    lsr_pkg::line_t store [DEPTH];
    lsr_pkg::line_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= store[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lsr_front.sv @@
module lsr_front #(
    parameter int MAX_GRID = lsr_pkg::MAX_GRID_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [lsr_pkg::GRID_W-1:0]         grid_size,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [lsr_pkg::U_W-1:0]     s_u,
    input  logic signed [lsr_pkg::DU_W-1:0]    s_du,
    input  logic                               s_last,
    output logic                               req_valid,
    input  logic                               req_ready,
    output lsr_pkg::req_t                      req
);

    localparam int AW = $clog2(MAX_GRID);
    localparam int NW = $clog2(MAX_GRID + 1);
    localparam int CW = $clog2(MAX_GRID + 2);

    typedef enum logic {RUN, FLUSH} state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   col_reg, col_next;
    logic [AW-1:0]   row_reg, row_next;
    logic [AW-1:0]   walk_reg, walk_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            has_a_reg, has_a_next;

    logic signed [lsr_pkg::U_W-1:0]  mid1_reg, mid1_next;
    logic signed [lsr_pkg::U_W-1:0]  mid2_reg, mid2_next;
    logic signed [lsr_pkg::U_W-1:0]  up_reg, up_next;
    logic signed [lsr_pkg::U_W-1:0]  down_reg, down_next;
    logic signed [lsr_pkg::DU_W-1:0] dmid_reg, dmid_next;
    logic signed [lsr_pkg::U_W-1:0]  a_cap_reg, a_cap_next;
    logic signed [lsr_pkg::U_W-1:0]  u_cap_reg, u_cap_next;

    logic [NW-1:0]   n;
    logic [AW-1:0]   nm1;
    logic            oob;
    logic [AW-1:0]   col_eff, row_eff, col_adv, walk_inc, walk_start;
    logic            acc, last_pos, flush, has_res, interior;
    logic signed [lsr_pkg::LAP_W-1:0] lap;

    logic            we;
    logic [AW-1:0]   rd_addr;
    lsr_pkg::line_t  rd_line, wr_line;

    // size in use, clamped
    always_comb
    begin
        if (grid_size < lsr_pkg::GRID_MIN)
        begin
            n = NW'(lsr_pkg::GRID_MIN);
        end
        else if (grid_size > lsr_pkg::GRID_W'(MAX_GRID))
        begin
            n = NW'(MAX_GRID);
        end
        else
        begin
            n = NW'(grid_size);
        end
    end

    assign nm1 = AW'(n - NW'(1));

    // stale position after a size change restarts at the origin
    assign oob     = (NW'(col_reg) >= n) || (NW'(row_reg) >= n);
    assign col_eff = oob ? '0 : col_reg;
    assign row_eff = oob ? '0 : row_reg;

    assign s_ready  = (state_reg == RUN) && req_ready;
    assign acc      = s_valid && s_ready;
    assign last_pos = (row_eff == nm1) && (col_eff == nm1);
    assign flush    = s_last || last_pos;

    // reported point is (row-1, col-1); first one once n+2 points are in
    assign has_res  = (row_eff >= AW'(2)) || ((row_eff == AW'(1)) && (col_eff != '0));
    assign interior = (row_eff >= AW'(2)) && (col_eff >= AW'(2));

    assign col_adv    = (col_eff == nm1) ? '0 : col_eff + AW'(1);
    assign walk_inc   = (walk_reg == nm1) ? '0 : walk_reg + AW'(1);
    assign walk_start = (row_eff != '0) ? col_adv : '0;

    // left = mid2, right = line read, up = last upper-row read, down = last input
    assign lap = lsr_pkg::LAP_W'(mid2_reg) + lsr_pkg::LAP_W'(rd_line.u1)
               + lsr_pkg::LAP_W'(up_reg) + lsr_pkg::LAP_W'(down_reg)
               - (lsr_pkg::LAP_W'(mid1_reg) <<< 2);

    assign wr_line.u1 = s_u;
    assign wr_line.d1 = s_du;
    assign wr_line.u2 = rd_line.u1;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        walk_next  = walk_reg;
        cnt_next   = cnt_reg;
        has_a_next = has_a_reg;
        mid1_next  = mid1_reg;
        mid2_next  = mid2_reg;
        up_next    = up_reg;
        down_next  = down_reg;
        dmid_next  = dmid_reg;
        a_cap_next = a_cap_reg;
        u_cap_next = u_cap_reg;
        req_valid  = 1'b0;
        req        = '0;
        we         = 1'b0;
        rd_addr    = col_eff;

        unique case (state_reg)
            RUN:
            begin
                req.interior = interior;
                req.last     = !flush;
                req.value    = mid1_reg;
                req.deriv    = dmid_reg;
                req.lap      = lap;
                if (acc)
                begin
                    we        = 1'b1;
                    req_valid = has_res;
                    mid1_next = rd_line.u1;
                    mid2_next = mid1_reg;
                    up_next   = rd_line.u2;
                    down_next = s_u;
                    dmid_next = rd_line.d1;
                    if (flush)
                    begin
                        state_next = FLUSH;
                        col_next   = '0;
                        row_next   = '0;
                        walk_next  = walk_start;
                        has_a_next = (row_eff != '0);
                        cnt_next   = (row_eff != '0) ? CW'(n) + CW'(1)
                                                     : CW'(col_eff) + CW'(1);
                        a_cap_next = rd_line.u1;
                        u_cap_next = s_u;
                        rd_addr    = walk_start;
                    end
                    else
                    begin
                        col_next = col_adv;
                        row_next = (col_eff == nm1) ? row_eff + AW'(1) : row_eff;
                        rd_addr  = col_adv;
                    end
                end
            end
            FLUSH:
            begin
                // oldest first: upper-row point under the cursor, line memory, then input
                req_valid = 1'b1;
                rd_addr   = walk_reg;
                if (has_a_reg)
                begin
                    req.value = a_cap_reg;
                end
                else if (cnt_reg == CW'(1))
                begin
                    req.value = u_cap_reg;
                    req.last  = 1'b1;
                end
                else
                begin
                    req.value = rd_line.u1;
                end
                if (req_ready)
                begin
                    cnt_next = cnt_reg - CW'(1);
                    if (has_a_reg)
                    begin
                        has_a_next = 1'b0;
                    end
                    else if (cnt_reg == CW'(1))
                    begin
                        state_next = RUN;
                        rd_addr    = '0;
                    end
                    else
                    begin
                        walk_next = walk_inc;
                        rd_addr   = walk_inc;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RUN;
            col_reg   <= '0;
            row_reg   <= '0;
            walk_reg  <= '0;
            cnt_reg   <= '0;
            has_a_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            walk_reg  <= walk_next;
            cnt_reg   <= cnt_next;
            has_a_reg <= has_a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid1_reg  <= mid1_next;
        mid2_reg  <= mid2_next;
        up_reg    <= up_next;
        down_reg  <= down_next;
        dmid_reg  <= dmid_next;
        a_cap_reg <= a_cap_next;
        u_cap_reg <= u_cap_next;
    end

    lsr_line_mem #(
        .DEPTH (MAX_GRID)
    ) u_line_mem (
        .clk   (clk),
        .we    (we),
        .waddr (col_eff),
        .wdata (wr_line),
        .raddr (rd_addr),
        .rdata (rd_line)
    );

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FLUSH) |-> ((cnt_reg != '0) && (cnt_reg <= CW'(MAX_GRID + 1))))
        else $error("flush count out of range");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FLUSH) |-> (NW'(walk_reg) < n))
        else $error("flush walk beyond grid row");

    a_flush_origin: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == RUN) && $past(state_reg == FLUSH)) |->
        ((col_reg == '0) && (row_reg == '0)))
        else $error("frame did not restart at origin after flush");
`endif

endmodule

@@ rtl/lsr_arith.sv @@
module lsr_arith (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lsr_pkg::COEFF_W-1:0]         coeff,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  lsr_pkg::req_t                       req,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lsr_pkg::RES_W-1:0]    m_residual,
    output logic                                m_bnd,
    output logic                                m_last
);

    localparam int QW = lsr_pkg::PROD_W - 8;

    localparam logic signed [lsr_pkg::RES_W-1:0] RES_MAX = {1'b0, {(lsr_pkg::RES_W-1){1'b1}}};
    localparam logic signed [lsr_pkg::RES_W-1:0] RES_MIN = {1'b1, {(lsr_pkg::RES_W-1){1'b0}}};

    logic                                   s1_v_reg;
    lsr_pkg::req_t                          s1_reg;
    logic                                   s2_v_reg;
    logic signed [lsr_pkg::PROD_W-1:0]      s2_prod_reg;
    logic signed [lsr_pkg::DU_W-1:0]        s2_deriv_reg;
    logic signed [lsr_pkg::U_W-1:0]         s2_value_reg;
    logic                                   s2_int_reg;
    logic                                   s2_last_reg;
    logic                                   out_v_reg;
    logic signed [lsr_pkg::RES_W-1:0]       out_res_reg;
    logic                                   out_bnd_reg;
    logic                                   out_last_reg;

    logic                                   out_ready, s2_ready;
    logic signed [lsr_pkg::PROD_W-1:0]      prod, rounded;
    logic signed [QW-1:0]                   quot;
    logic signed [lsr_pkg::DIFF_W-1:0]      diff;
    logic [lsr_pkg::DIFF_W-lsr_pkg::RES_W:0] diff_top;
    logic signed [lsr_pkg::RES_W-1:0]       res;

    assign out_ready = !out_v_reg || m_ready;
    assign s2_ready  = !s2_v_reg || out_ready;
    assign req_ready = !s1_v_reg || s2_ready;

    assign prod = s1_reg.lap * $signed({1'b0, coeff});

    // round Q.24 to Q.16: add half, floor by 2^8
    assign rounded  = s2_prod_reg + lsr_pkg::PROD_W'(128);
    assign quot     = rounded[lsr_pkg::PROD_W-1:8];
    assign diff     = lsr_pkg::DIFF_W'(s2_deriv_reg) - lsr_pkg::DIFF_W'(quot);
    assign diff_top = diff[lsr_pkg::DIFF_W-1:lsr_pkg::RES_W-1];

    always_comb
    begin
        if (!s2_int_reg)
        begin
            res = lsr_pkg::RES_W'(s2_value_reg);
        end
        else if ((diff_top == '0) || (diff_top == '1))
        begin
            res = diff[lsr_pkg::RES_W-1:0];
        end
        else if (diff[lsr_pkg::DIFF_W-1])
        begin
            res = RES_MIN;
        end
        else
        begin
            res = RES_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_v_reg <= req_valid;
            end
            if (s2_ready)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (out_ready)
            begin
                out_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            s1_reg <= req;
        end
        if (s2_ready && s1_v_reg)
        begin
            s2_prod_reg  <= prod;
            s2_deriv_reg <= s1_reg.deriv;
            s2_value_reg <= s1_reg.value;
            s2_int_reg   <= s1_reg.interior;
            s2_last_reg  <= s1_reg.last;
        end
        if (out_ready && s2_v_reg)
        begin
            out_res_reg  <= res;
            out_bnd_reg  <= !s2_int_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_valid    = out_v_reg;
    assign m_residual = out_res_reg;
    assign m_bnd      = out_bnd_reg;
    assign m_last     = out_last_reg;

endmodule

@@ rtl/laplacian_stencil_residual.sv @@
// Five-point Laplacian residual over a square grid streamed in raster order.
// A point's result is formed at the beat that completes its stencil (one grid
// row plus one point after it) and leaves via the s1, s2 and output registers.
// Throughput: one point per cycle while the result side keeps up; a frame end
// holds s_axis_tready low while pending points are read back from the line memory.
// Reset: rst_n clears the position counters and pipeline valids; the line
// memory is not cleared, since only entries written in the current frame are read.
module laplacian_stencil_residual #(
    parameter int MAX_GRID = lsr_pkg::MAX_GRID_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [47:0]                   s_axis_tdata,   // [23:0] u_value, [47:24] du_value
    input  logic                          s_axis_tlast,   // frame_end

    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // [31:0] residual
    output logic                          m_axis_tuser,   // on_boundary
    output logic                          m_axis_tlast,   // run_last

    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsr_pkg::PADDR_W-1:0]   paddr,
    input  logic [lsr_pkg::PDATA_W-1:0]   pwdata,
    output logic [lsr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    // Register map: word 0 grid_size, word 1 coeff. Only paddr[2] decodes.
    localparam logic REG_GRID  = 1'b0;
    localparam logic REG_COEFF = 1'b1;

    logic [lsr_pkg::GRID_W-1:0]  grid_size_reg;
    logic [lsr_pkg::COEFF_W-1:0] coeff_reg;
    logic                        cfg_wr;

    logic                        req_valid, req_ready;
    lsr_pkg::req_t               req;
    logic signed [lsr_pkg::RES_W-1:0] residual;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= lsr_pkg::GRID_RST;
            coeff_reg     <= lsr_pkg::COEFF_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_GRID:  grid_size_reg <= pwdata[lsr_pkg::GRID_W-1:0];
                REG_COEFF: coeff_reg     <= pwdata[lsr_pkg::COEFF_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_GRID:  prdata = lsr_pkg::PDATA_W'(grid_size_reg);
            REG_COEFF: prdata = lsr_pkg::PDATA_W'(coeff_reg);
        endcase
    end

    // Position tracking, line memory (one entry per column holding the two
    // most recent rows), stencil taps and the end-of-frame readback.
    lsr_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid_size (grid_size_reg),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_u       (s_axis_tdata[23:0]),
        .s_du      (s_axis_tdata[47:24]),
        .s_last    (s_axis_tlast),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    // Multiply by coeff, round, subtract from du, saturate (boundary points pass
    // their value through); elastic stages whose ready chains combinationally from m_ready.
    lsr_arith u_arith (
        .clk        (clk),
        .rst_n      (rst_n),
        .coeff      (coeff_reg),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_residual (residual),
        .m_bnd      (m_axis_tuser),
        .m_last     (m_axis_tlast)
    );

    assign m_axis_tdata = residual;

endmodule

@@ dv/laplacian_stencil_residual_test.sv @@
`timescale 1ns / 1ps

module laplacian_stencil_residual_test;

    import lsr_pkg::*;

    // Register map: one 32-bit word per register.
    localparam logic [PADDR_W-1:0] REG_GRID_SIZE = 3'd0;
    localparam logic [PADDR_W-1:0] REG_COEFF     = 3'd4;

    localparam int MAX_SIDE  = MAX_GRID_DEF;
    localparam int WIN_DEPTH = 2 * MAX_SIDE + 1;
    localparam int DLY_DEPTH = MAX_SIDE + 1;

    localparam logic [U_W-1:0]     U_MAX   = 24'h7FFFFF;
    localparam logic [U_W-1:0]     U_MIN   = 24'h800000;
    localparam logic [COEFF_W-1:0] C_MAX   = 24'hFFFFFF;
    localparam logic [RES_W-1:0]   RES_MAX = 32'h7FFFFFFF;
    localparam logic [RES_W-1:0]   RES_MIN = 32'h80000000;

    // Quiet time after the last result before a register write or the verdict.
    // Covers the pipeline plus frame-start beats that produce nothing.
    localparam int SETTLE_CYCLES = 16;
    // Long receiver hold-off so the block backs up and drops s_axis_tready.
    localparam int HOLD_CYCLES   = 300;

    localparam int NUM_PHASES     = 12;
    localparam int PRESSURE_PHASE = 2;
    localparam int COEFF_RANDOM   = -1;

    typedef struct packed {
        logic [RES_W-1:0] residual;
        logic             on_boundary;
        logic             run_last;
    } point_result_t;

    // Directed stimulus row; typed rows carry the hand-computed first result.
    typedef struct packed {
        logic [U_W-1:0]   u;
        logic [DU_W-1:0]  du;
        logic             frame_end;
        logic             typed;
        logic [RES_W-1:0] res;
        logic             bnd;
    } directed_row_t;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_e;

    logic                clk;
    logic                rst_n;

    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [47:0]         s_axis_tdata;   // [23:0] u_value, [47:24] du_value
    logic                s_axis_tlast;   // frame_end

    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [31:0]         m_axis_tdata;   // [31:0] residual
    logic                m_axis_tuser;   // on_boundary
    logic                m_axis_tlast;   // run_last

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    laplacian_stencil_residual DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // Shadow state of the stencil: config copy, sliding windows, position
    // ------------------------------------------------------------------
    logic [GRID_W-1:0]  grid_reg;
    logic [COEFF_W-1:0] coeff_reg;
    logic [U_W-1:0]     u_hist  [WIN_DEPTH];   // [0] = newest value
    logic [DU_W-1:0]    du_hist [DLY_DEPTH];   // [0] = newest derivative
    int                 pred_col;
    int                 pred_row;

    point_result_t      residual_q[$];        // results still owed by the block
    int                 mismatch_count;

    // Sender / receiver pacing
    int                 burst_left;
    logic               gaps_on;
    logic               hold_rx;

    function automatic int grid_side(logic [GRID_W-1:0] g);
        int n;
        n = int'(g);
        if (n < 3) n = 3;
        if (n > MAX_SIDE) n = MAX_SIDE;
        return n;
    endfunction

    function automatic longint sx24(logic [23:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [RES_W-1:0] sat32(longint v);
        if (v > 64'sd2147483647) return RES_MAX;
        if (v < -64'sd2147483648) return RES_MIN;
        return 32'(v);
    endfunction

    function automatic logic [RES_W-1:0] edge_residual(logic [U_W-1:0] u);
        return {{(RES_W-U_W){u[U_W-1]}}, u};
    endfunction

    // Works out every result caused by one accepted point and queues them.
    // A typed row overrides residual/boundary of the first result.
    task automatic predict_residuals(input logic [U_W-1:0] u, input logic [DU_W-1:0] du,
                                     input logic frame_end, input logic typed,
                                     input logic [RES_W-1:0] typed_res, input logic typed_bnd);
        int            n, q, pr, pc, m, d, i;
        logic          flush;
        longint        lap, prod, res;
        point_result_t r;
        point_result_t outs[$];

        n = grid_side(grid_reg);
        // position beyond the grid after a size change: restart at (0,0)
        if (pred_col >= n || pred_row >= n) begin
            pred_col = 0;
            pred_row = 0;
        end
        q = pred_row * n + pred_col;
        // implicit frame end at the last grid position
        flush = frame_end || (q == n * n - 1);

        // regular result for the point one row plus one point back
        if (q >= n + 1) begin
            if (pred_col == 0) begin
                pc = n - 1;
                pr = pred_row - 2;
            end
            else begin
                pc = pred_col - 1;
                pr = pred_row - 1;
            end
            r.run_last = 1'b0;
            if (pr == 0 || pr == n - 1 || pc == 0 || pc == n - 1) begin
                r.residual    = edge_residual(u_hist[n]);
                r.on_boundary = 1'b1;
            end
            else begin
                lap = sx24(u_hist[n + 1]) + sx24(u_hist[n - 1]) + sx24(u_hist[2 * n])
                    + sx24(u_hist[0]) - 4 * sx24(u_hist[n]);
                prod = lap * longint'(coeff_reg);
                // round Q.24 to Q.16: add half, floor-divide by 256
                res = sx24(du_hist[n]) - ((prod + 128) >>> 8);
                r.residual    = sat32(res);
                r.on_boundary = 1'b0;
            end
            outs.push_back(r);
        end

        // flush pending points oldest first, then the current one
        if (flush) begin
            m = (q + 1 < n + 1) ? q + 1 : n + 1;
            r.on_boundary = 1'b1;
            r.run_last    = 1'b0;
            for (d = m - 1; d >= 1; d--) begin
                r.residual = edge_residual(u_hist[d - 1]);
                outs.push_back(r);
            end
            r.residual = edge_residual(u);
            outs.push_back(r);
        end

        if (outs.size() > 0) begin
            outs[outs.size() - 1].run_last = 1'b1;
            if (typed) begin
                outs[0].residual    = typed_res;
                outs[0].on_boundary = typed_bnd;
            end
        end
        foreach (outs[k]) residual_q.push_back(outs[k]);

        for (i = WIN_DEPTH - 1; i > 0; i--) u_hist[i] = u_hist[i - 1];
        u_hist[0] = u;
        for (i = DLY_DEPTH - 1; i > 0; i--) du_hist[i] = du_hist[i - 1];
        du_hist[0] = du;

        if (flush) begin
            pred_col = 0;
            pred_row = 0;
        end
        else begin
            pred_col++;
            if (pred_col >= n) begin
                pred_col = 0;
                pred_row++;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Bus drivers; all called and returning at a falling edge
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (addr)
            REG_GRID_SIZE: grid_reg  = data[GRID_W-1:0];
            REG_COEFF:     coeff_reg = data[COEFF_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // One grid point beat. Bursts with random gaps; valid stays high across
    // back-to-back beats.
    task automatic send_point(input logic [U_W-1:0] u, input logic [DU_W-1:0] du,
                              input logic frame_end, input logic typed,
                              input logic [RES_W-1:0] typed_res, input logic typed_bnd);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if ($urandom_range(0, 15) == 0) gap = 30;
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tdata  = {du, u};
        s_axis_tlast  = frame_end;
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        predict_residuals(u, du, frame_end, typed, typed_res, typed_bnd);
        if (burst_left > 0) burst_left--;
        @(negedge clk);
    endtask

    // Drop valid, wait out every owed result, then let the pipeline go quiet.
    task automatic settle();
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (residual_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mix of extremes, small values (unsaturated arithmetic) and full range.
    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return U_MAX;
            1:       return U_MIN;
            2:       return 24'h0;
            3, 4, 5: return 24'($urandom_range(0, 8191) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: changing ready patterns, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int          left;
        rx_pattern_e pat;
        left          = 0;
        pat           = RX_STEADY;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_rx) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_rx = 1'b0;
            end
            else begin
                if (left == 0) begin
                    pat  = rx_pattern_e'($urandom_range(0, 3));
                    left = $urandom_range(8, 80);
                end
                left--;
                case (pat)
                    RX_STEADY: m_axis_tready = 1'b1;
                    RX_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready = ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready = ~m_axis_tready;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        point_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (residual_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat residual=%h", m_axis_tdata));
            end
            else begin
                want = residual_q.pop_front();
                if (m_axis_tdata !== want.residual)
                    report_mismatch($sformatf("residual %h, expected %h",
                                              m_axis_tdata, want.residual));
                if (m_axis_tuser !== want.on_boundary)
                    report_mismatch($sformatf("on_boundary %b, expected %b",
                                              m_axis_tuser, want.on_boundary));
                if (m_axis_tlast !== want.run_last)
                    report_mismatch($sformatf("run_last %b, expected %b",
                                              m_axis_tlast, want.run_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Directed part runs on a 3x3 grid (size register 0, clamped up) with
    // the largest coeff. Frame A: interior point with all neighbors at max
    // and center at min -> negative saturation; implicit end at the last
    // position. Frame B: mirror image -> positive saturation, with an
    // explicit frame end too. Frame C: truncated frame that still gets one
    // regular result. Frame D: single-point frame.
    directed_row_t directed_rows [24] = '{
        // frame A
        '{U_MAX,  U_MIN,  1'b0, 1'b0, 32'h0,     1'b0},
        '{U_MAX,  U_MAX,  1'b0, 1'b0, 32'h0,     1'b0},
        '{U_MIN,  24'h0,  1'b0, 1'b0, 32'h0,     1'b0},
        '{U_MAX,  24'h0,  1'b0, 1'b0, 32'h0,     1'b0},
        '{U_MIN,  U_MIN,  1'b0, 1'b1, 32'h007FFFFF, 1'b1},
        '{U_MAX,  U_MAX,  1'b0, 1'b1, 32'h007FFFFF, 1'b1},
        '{24'h0,  U_MIN,  1'b0, 1'b1, 32'hFF800000, 1'b1},
        '{U_MAX,  24'h0,  1'b0, 1'b1, 32'h007FFFFF, 1'b1},
        '{U_MIN,  U_MAX,  1'b0, 1'b1, RES_MIN,   1'b0},
        // frame B
        '{U_MIN,  U_MAX,  1'b0, 1'b0, 32'h0,     1'b0},
        '{U_MIN,  U_MIN,  1'b0, 1'b0, 32'h0,     1'b0},
        '{U_MAX,  U_MAX,  1'b0, 1'b0, 32'h0,     1'b0},
        '{U_MIN,  U_MIN,  1'b0, 1'b0, 32'h0,     1'b0},
        '{U_MAX,  U_MAX,  1'b0, 1'b1, 32'hFF800000, 1'b1},
        '{U_MIN,  24'h0,  1'b0, 1'b1, 32'hFF800000, 1'b1},
        '{24'h0,  24'h0,  1'b0, 1'b1, 32'h007FFFFF, 1'b1},
        '{U_MIN,  U_MAX,  1'b0, 1'b1, 32'hFF800000, 1'b1},
        '{U_MAX,  U_MIN,  1'b1, 1'b1, RES_MAX,   1'b0},
        // frame C: cut short after five points
        '{24'h1,  24'h10, 1'b0, 1'b0, 32'h0,     1'b0},
        '{24'h2,  24'h20, 1'b0, 1'b0, 32'h0,     1'b0},
        '{24'h3,  24'h30, 1'b0, 1'b0, 32'h0,     1'b0},
        '{24'h4,  24'h40, 1'b0, 1'b0, 32'h0,     1'b0},
        '{24'h5,  24'h50, 1'b1, 1'b1, 32'h1,     1'b1},
        // frame D: one point, flushed at once
        '{24'hFFFFFF, 24'h1, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b1}
    };

    // Random phases: raw size register values (0..2 and >32 exercise the
    // clamp) and coeff per phase. Phase PRESSURE_PHASE runs gap-free while
    // the receiver holds off.
    int grid_plan  [NUM_PHASES] = '{5, 63, 4, 1, 8, 33, 6, 0, 3, 12, 2, 7};
    int coeff_plan [NUM_PHASES] = '{COEFF_RANDOM, 0, 16777215, COEFF_RANDOM, 20736,
                                    COEFF_RANDOM, 1, COEFF_RANDOM, 256, COEFF_RANDOM,
                                    16777215, 0};

    initial begin
        int            p, k, n, next_n, len, budget, sent;
        logic          full_frame, fe;
        logic [23:0]   cval;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hold_rx        = 1'b0;
        gaps_on        = 1'b1;
        burst_left     = 0;
        mismatch_count = 0;

        grid_reg  = GRID_RST;
        coeff_reg = COEFF_RST;
        foreach (u_hist[i]) u_hist[i] = '0;
        foreach (du_hist[i]) du_hist[i] = '0;
        pred_col = 0;
        pred_row = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table; size 0 is used as 3
        apb_write(REG_GRID_SIZE, 32'h0);
        apb_write(REG_COEFF, {8'hA5, C_MAX});
        foreach (directed_rows[i])
            send_point(directed_rows[i].u, directed_rows[i].du, directed_rows[i].frame_end,
                       directed_rows[i].typed, directed_rows[i].res, directed_rows[i].bnd);
        settle();

        for (p = 0; p < NUM_PHASES; p++) begin
            // junk in the unused high bits of pwdata
            apb_write(REG_GRID_SIZE, ($urandom & ~32'h3F) | 32'(grid_plan[p]));
            cval = (coeff_plan[p] == COEFF_RANDOM) ? 24'($urandom) : 24'(coeff_plan[p]);
            apb_write(REG_COEFF, {8'($urandom), cval});
            n = grid_side(grid_reg);

            budget = (n == MAX_SIDE) ? 60 : 25;
            if (p == PRESSURE_PHASE) begin
                budget  = 80;
                gaps_on = 1'b0;
                hold_rx = 1'b1;
            end

            // mostly whole or truncated frames with random content
            sent = 0;
            while (sent < budget) begin
                full_frame = (n <= 8) && ($urandom_range(0, 2) == 0);
                len = full_frame ? n * n
                                 : $urandom_range(1, (3*n + 5 < n*n - 1) ? 3*n + 5 : n*n - 1);
                for (k = 0; k < len; k++) begin
                    if (k == len - 1)
                        fe = full_frame ? 1'($urandom_range(0, 1)) : 1'b1;
                    else
                        fe = 1'b0;
                    send_point(rand_sample(), rand_sample(), fe, 1'b0, '0, 1'b0);
                end
                sent += len;
            end

            // sometimes leave a frame open so the next size change lands the
            // position outside the grid; close it if it would not
            if (p < NUM_PHASES - 1 && $urandom_range(0, 2) == 0) begin
                next_n = grid_side(GRID_W'(grid_plan[p + 1]));
                len = $urandom_range(1, (2*n + 6 < n*n - 2) ? 2*n + 6 : n*n - 2);
                for (k = 0; k < len; k++)
                    send_point(rand_sample(), rand_sample(), 1'b0, 1'b0, '0, 1'b0);
                if (pred_col < next_n && pred_row < next_n)
                    send_point(rand_sample(), rand_sample(), 1'b1, 1'b0, '0, 1'b0);
            end

            gaps_on = 1'b1;
            settle();
        end

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
